### design/pmsm_back_emf_observer_defines.svh
// ----------------------------------------------------------------------------
// pmsm back-emf observer assertion macros
// shared concurrent assertion forms, all reset-qualified
// ----------------------------------------------------------------------------
`ifndef PMSM_BACK_EMF_OBSERVER_DEFINES_SVH
`define PMSM_BACK_EMF_OBSERVER_DEFINES_SVH

// same-cycle implication
`define PBEO_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pbeo assertion failed");

// next-cycle implication
`define PBEO_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pbeo assertion failed");

`endif

### design/pbeo_pkg.sv
// ----------------------------------------------------------------------------
// pbeo_pkg
// shared types, codes and arithmetic helpers of the back-emf observer
// ----------------------------------------------------------------------------
package pbeo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int STEP_W           = 5;
  localparam int OP_W             = 4;
  localparam int CFG_ADDR_W       = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_TIME  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_OVER_L = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RESISTANCE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CUR_GAIN   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EMF_GAIN   = 3'd4;

  // multiply-accumulate operation sequence
  localparam logic [OP_W-1:0] OP_RS_A   = 4'd0;
  localparam logic [OP_W-1:0] OP_KS_A   = 4'd1;
  localparam logic [OP_W-1:0] OP_TS_A   = 4'd2;
  localparam logic [OP_W-1:0] OP_TSL_A  = 4'd3;
  localparam logic [OP_W-1:0] OP_RS_B   = 4'd4;
  localparam logic [OP_W-1:0] OP_KS_B   = 4'd5;
  localparam logic [OP_W-1:0] OP_TS_B   = 4'd6;
  localparam logic [OP_W-1:0] OP_TSL_B  = 4'd7;
  localparam logic [OP_W-1:0] OP_W_SPD  = 4'd8;
  localparam logic [OP_W-1:0] OP_W_EB   = 4'd9;
  localparam logic [OP_W-1:0] OP_KL_B   = 4'd10;
  localparam logic [OP_W-1:0] OP_TS_RA  = 4'd11;
  localparam logic [OP_W-1:0] OP_W_EA   = 4'd12;
  localparam logic [OP_W-1:0] OP_KL_A   = 4'd13;
  localparam logic [OP_W-1:0] OP_TS_RB  = 4'd14;
  localparam logic [OP_W-1:0] OP_LAST   = OP_TS_RB;

  localparam logic signed [32:0] PI_Q16 = 33'sd205887;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              post_en;
    logic [OP_W-1:0]   op;
    logic              cord_init;
    logic              cord_step;
    logic [STEP_W-1:0] step;
    logic              finish;
  } pbeo_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } pbeo_stat_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sh0_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -52'sh0_0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // arctangent table, 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### design/pbeo_ctrl.sv
// ----------------------------------------------------------------------------
// pbeo_ctrl
// sequencer: multiply/post ops, cordic iterations, result handoff
// ----------------------------------------------------------------------------
`include "pmsm_back_emf_observer_defines.svh"

module pbeo_ctrl
  import pbeo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  pbeo_stat_t stat,
  output pbeo_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_POST  = 3'd2;
  localparam logic [2:0] ST_CINIT = 3'd3;
  localparam logic [2:0] ST_CORD  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic [2:0]        state, state_next;
  logic [OP_W-1:0]   op, op_next;
  logic [STEP_W-1:0] step, step_next;

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    op_next       = op;
    step_next     = step;
    cmd           = '0;
    cmd.op        = op;
    cmd.step      = step;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          op_next    = OP_RS_A;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_POST;
      end
      ST_POST: begin
        cmd.post_en = 1'b1;
        if (op == OP_LAST) begin
          state_next = ST_CINIT;
        end else begin
          op_next    = op + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_CINIT: begin
        cmd.cord_init = 1'b1;
        step_next     = '0;
        state_next    = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        if (step == STEP_LAST) begin
          state_next = ST_FIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      step  <= step_next;
    end
  end

  `PBEO_ASSERT_NEXT(a_load_starts_ops, clk, rst, cmd.load, state == ST_MUL && op == OP_RS_A)
  `PBEO_ASSERT_NEXT(a_mul_then_post, clk, rst, cmd.mul_en, cmd.post_en && $stable(op))
  `PBEO_ASSERT_NEXT(a_cord_end, clk, rst, cmd.cord_step && step == STEP_LAST, state == ST_FIN)
  `PBEO_ASSERT_SAME(a_finish_free, clk, rst, cmd.finish, !stat.out_busy)

endmodule

### design/pbeo_datapath.sv
// ----------------------------------------------------------------------------
// pbeo_datapath
// state, config registers, shared multiplier, cordic rotator, output register
// ----------------------------------------------------------------------------
module pbeo_datapath
  import pbeo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  pbeo_cmd_t             cmd,
  output pbeo_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_data,
  input  logic [127:0]          s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [95:0]           m_tdata
);

  // configuration
  logic [31:0] step_time, step_over_l, resistance, cur_gain, emf_gain;

  // observer state
  logic signed [31:0] cur_a, cur_b, emf_a, emf_b;
  logic signed [15:0] speed, prev_angle;

  // per-sample working registers
  logic signed [31:0] volt_a, volt_b, err_a, err_b;
  logic signed [31:0] drive, kerr, rate, w, emf_a_new, emf_b_new;
  logic signed [51:0] slide, rot;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;

  // cordic
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic               czero;

  // output register
  logic [15:0] out_angle, out_speed;
  logic [31:0] out_ea, out_eb;

  assign stat.out_busy = m_tvalid && !m_tready;
  assign m_tdata = {out_eb, out_ea, out_speed, out_angle};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= 32'd214748;
      step_over_l <= 32'd327680;
      resistance  <= 32'd65536;
      cur_gain    <= 32'd65536;
      emf_gain    <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP_TIME:   step_time   <= cfg_data;
        REG_STEP_OVER_L: step_over_l <= cfg_data;
        REG_RESISTANCE:  resistance  <= cfg_data;
        REG_CUR_GAIN:    cur_gain    <= cfg_data;
        REG_EMF_GAIN:    emf_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_a = {1'b0, step_time};
    mul_b = 33'(err_a);
    case (cmd.op)
      OP_RS_A:  begin mul_a = {1'b0, resistance};  mul_b = 33'(cur_a); end
      OP_KS_A:  begin mul_a = {1'b0, cur_gain};    mul_b = 33'(err_a); end
      OP_TS_A:  begin mul_a = {1'b0, step_time};   mul_b = 33'(kerr);  end
      OP_TSL_A: begin mul_a = {1'b0, step_over_l}; mul_b = 33'(drive); end
      OP_RS_B:  begin mul_a = {1'b0, resistance};  mul_b = 33'(cur_b); end
      OP_KS_B:  begin mul_a = {1'b0, cur_gain};    mul_b = 33'(err_b); end
      OP_TS_B:  begin mul_a = {1'b0, step_time};   mul_b = 33'(kerr);  end
      OP_TSL_B: begin mul_a = {1'b0, step_over_l}; mul_b = 33'(drive); end
      OP_W_SPD: begin mul_a = 33'(speed);          mul_b = PI_Q16;     end
      OP_W_EB:  begin mul_a = 33'(w);              mul_b = 33'(emf_b); end
      OP_KL_B:  begin mul_a = {1'b0, emf_gain};    mul_b = 33'(err_b); end
      OP_TS_RA: begin mul_a = {1'b0, step_time};   mul_b = 33'(rate);  end
      OP_W_EA:  begin mul_a = 33'(w);              mul_b = 33'(emf_a); end
      OP_KL_A:  begin mul_a = {1'b0, emf_gain};    mul_b = 33'(err_a); end
      OP_TS_RB: begin mul_a = {1'b0, step_time};   mul_b = 33'(rate);  end
      default:  begin mul_a = {1'b0, step_time};   mul_b = 33'(err_a); end
    endcase
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // post-processing of the product
  logic signed [65:0] p16, p32, p15;
  logic signed [51:0] q16, q32;
  assign p16 = prod >>> 16;
  assign p32 = prod >>> 32;
  assign p15 = prod >>> 15;
  assign q16 = p16[51:0];
  assign q32 = p32[51:0];

  // sample capture, op results, state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_a <= '0;
      cur_b <= '0;
      emf_a <= '0;
      emf_b <= '0;
    end else begin
      if (cmd.post_en) begin
        case (cmd.op)
          OP_TSL_A: cur_a <= sat32(52'(cur_a) + q16 - slide);
          OP_TSL_B: cur_b <= sat32(52'(cur_b) + q16 - slide);
          default: ;
        endcase
      end
      if (cmd.cord_init) begin
        emf_a <= emf_a_new;
        emf_b <= emf_b_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      volt_a <= s_tdata[31:0];
      volt_b <= s_tdata[63:32];
      err_a  <= sat32(52'(cur_a) - 52'($signed(s_tdata[95:64])));
      err_b  <= sat32(52'(cur_b) - 52'($signed(s_tdata[127:96])));
    end
    if (cmd.post_en) begin
      case (cmd.op)
        OP_RS_A:  drive <= sat32(52'(volt_a) - q16 - 52'(emf_a));
        OP_RS_B:  drive <= sat32(52'(volt_b) - q16 - 52'(emf_b));
        OP_KS_A, OP_KS_B: kerr <= sat32(q16);
        OP_TS_A, OP_TS_B: slide <= q32;
        OP_W_SPD: w <= p15[31:0];
        OP_W_EB:  rot <= -q16;
        OP_W_EA:  rot <= q16;
        OP_KL_A, OP_KL_B: rate <= sat32(rot + q16);
        OP_TS_RA: emf_a_new <= sat32(52'(emf_a) + q32);
        OP_TS_RB: emf_b_new <= sat32(52'(emf_b) + q32);
        default: ;
      endcase
    end
  end

  // cordic vectoring of (emf_beta, -emf_alpha)
  logic signed [35:0] ix, iy, sx, sy;
  logic signed [33:0] at;
  assign ix = 36'(emf_b_new);
  assign iy = -36'(emf_a_new);
  assign sx = cx >>> cmd.step;
  assign sy = cy >>> cmd.step;
  assign at = 34'(atan_turn(cmd.step));

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      czero <= (ix == '0) && (iy == '0);
      if (ix < 0) begin
        if (iy >= 0) begin
          cx <= iy;
          cy <= -ix;
          cz <= 34'sd1073741824;
        end else begin
          cx <= -iy;
          cy <= ix;
          cz <= -34'sd1073741824;
        end
      end else begin
        cx <= ix;
        cy <= iy;
        cz <= '0;
      end
    end else if (cmd.cord_step) begin
      if (cy > 0) begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + at;
      end else begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - at;
      end
    end
  end

  // final angle and speed
  logic signed [33:0] zr;
  logic signed [15:0] angle, dspeed;
  assign zr     = (cz + 34'sd32768) >>> 16;
  assign angle  = czero ? 16'sd0 : zr[15:0];
  assign dspeed = angle - prev_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= '0;
      prev_angle <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.finish) begin
        speed      <= dspeed;
        prev_angle <= angle;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_angle <= angle;
      out_speed <= dspeed;
      out_ea    <= emf_a;
      out_eb    <= emf_b;
    end
  end

endmodule

### design/pmsm_back_emf_observer.sv
// ----------------------------------------------------------------------------
// pmsm_back_emf_observer
// back-emf observer with cordic rotor angle and speed, one result per sample
// ----------------------------------------------------------------------------
// usage:
//   s_* channel: one sample per transfer (voltages and measured currents).
//   m_* channel: one result per sample (angle, speed, both back-emf values).
//   cfg_we/cfg_addr/cfg_data write the five gain registers while idle.
// operation:
//   fifteen multiply ops share one 33x33 multiplier, each a multiply step
//   then a post step of the product; after the last op comes the cordic
//   initialisation, then one cordic iteration per cycle.
//   s_tready is high only between samples, so a new sample is taken only
//   once the previous one has been finished.
// reset:
//   rst clears estimates, speed and angle history and loads default gains.
// stall:
//   the result waits in an output register; the next sample can be taken
//   meanwhile, and its result is held back until the previous one transfers.
// ----------------------------------------------------------------------------
module pmsm_back_emf_observer
  import pbeo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // volt_alpha, volt_beta, amp_alpha, amp_beta (32 bits each)
  input  logic [127:0]          s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // rotor_angle[15:0], rotor_speed[31:16], emf_alpha_est[63:32], emf_beta_est[95:64]
  output logic [95:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_data
);

  pbeo_cmd_t  cmd;
  pbeo_stat_t stat;

  // sequencer
  pbeo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic
  pbeo_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### tb/pmsm_back_emf_observer_tb.sv
// ----------------------------------------------------------------------------
// pmsm_back_emf_observer_tb
// drives voltage and current samples into the back-emf observer, predicts
// angle, speed and both back-emf values per sample, and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmsm_back_emf_observer_tb;
  import pbeo_pkg::*;

  localparam int STEPS = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic signed [31:0] emf_b;
    logic signed [31:0] emf_a;
    logic signed [15:0] speed;
    logic signed [15:0] angle;
  } observer_out_t;

  // predictor state and gains
  longint g_ts, g_tsl, g_rs, g_ks, g_kl;
  longint est_ia, est_ib, est_ea, est_eb, last_speed, last_angle;

  observer_out_t expected_results[$];
  int errors = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;

  pmsm_back_emf_observer #(.CORDIC_STEPS(STEPS)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #300ms;
    $display("pmsm_back_emf_observer_tb: FAIL");
    $finish;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  function automatic longint euler_current(longint cur, longint volt, longint amp,
                                           longint emf);
    longint err, drive, kerr, slide, delta;
    err = clamp32(cur - amp);
    drive = clamp32(volt - ((g_rs * cur) >>> 16) - emf);
    kerr = clamp32((g_ks * err) >>> 16);
    slide = (g_ts * kerr) >>> 32;
    delta = (g_tsl * drive) >>> 16;
    return clamp32(cur + delta - slide);
  endfunction

  function automatic longint emf_update(longint emf, longint rot, longint err);
    longint rate;
    rate = clamp32(rot + ((g_kl * err) >>> 16));
    return clamp32(emf + ((g_ts * rate) >>> 32));
  endfunction

  function automatic logic [15:0] vector_angle(longint x, longint y);
    longint z, t, dx, dy, r;
    z = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 1073741824;
      end else begin
        x = -y; y = t; z = -1073741824;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    r = (z + 32768) >>> 16;
    return r[15:0];
  endfunction

  // advance the observer model by one sample
  function automatic observer_out_t observe_sample(logic [127:0] d);
    longint va, vb, ia, ib, err_a, err_b, w, ea, eb, ang, spd;
    logic [15:0] a16, s16;
    observer_out_t r;
    va = longint'($signed(d[31:0]));
    vb = longint'($signed(d[63:32]));
    ia = longint'($signed(d[95:64]));
    ib = longint'($signed(d[127:96]));
    err_a = clamp32(est_ia - ia);
    err_b = clamp32(est_ib - ib);
    w = (last_speed * 205887) >>> 15;
    ea = est_ea;
    eb = est_eb;
    est_ia = euler_current(est_ia, va, ia, ea);
    est_ib = euler_current(est_ib, vb, ib, eb);
    est_ea = emf_update(ea, -((w * eb) >>> 16), err_b);
    est_eb = emf_update(eb, (w * ea) >>> 16, err_a);
    a16 = vector_angle(est_eb, -est_ea);
    ang = longint'($signed(a16));
    s16 = 16'(ang - last_angle);
    spd = longint'($signed(s16));
    last_speed = spd;
    last_angle = ang;
    r.angle = a16;
    r.speed = s16;
    r.emf_a = est_ea[31:0];
    r.emf_b = est_eb[31:0];
    return r;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_out || ($urandom_range(99) >= 21);
    end
  end

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    observer_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.angle !== want.angle)
          $display("%0t: angle expected %0d actual %0d", $time, want.angle, got.angle);
        if (got.speed !== want.speed)
          $display("%0t: speed expected %0d actual %0d", $time, want.speed, got.speed);
        if (got.emf_a !== want.emf_a)
          $display("%0t: emf_alpha expected %0d actual %0d", $time, want.emf_a, got.emf_a);
        if (got.emf_b !== want.emf_b)
          $display("%0t: emf_beta expected %0d actual %0d", $time, want.emf_b, got.emf_b);
        if (got !== want) errors++;
      end
    end
  end

  // tvalid stays high after a transfer until the next sample or an idle cycle
  task automatic send_sample(logic [31:0] va, logic [31:0] vb, logic [31:0] ia,
                             logic [31:0] ib);
    while (!quiet_in && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ib, ia, vb, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(observe_sample({ib, ia, vb, va}));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_gain(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_TIME:   g_ts = val;
      REG_STEP_OVER_L: g_tsl = val;
      REG_RESISTANCE:  g_rs = val;
      REG_CUR_GAIN:    g_ks = val;
      REG_EMF_GAIN:    g_kl = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(65536 * 40) - 65536 * 20;
      default: return $urandom();
    endcase
  endfunction

  // extremes of every field, zero vector and saturation
  task automatic test_directed();
    send_sample(0, 0, 0, 0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int i = 0; i < 10; i++)
      send_sample(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 32'hFFFF_8000);
    drain_results();
  endtask

  // gain settings including extremes
  task automatic test_gain_sweep();
    for (int s = 0; s < 6; s++) begin
      write_gain(REG_STEP_TIME, s == 0 ? 32'hFFFF_FFFF : s == 1 ? 32'd0 : $urandom());
      write_gain(REG_STEP_OVER_L, s == 0 ? 32'hFFFF_FFFF : s == 1 ? 32'd0 : $urandom());
      write_gain(REG_RESISTANCE, s == 0 ? 32'hFFFF_FFFF : s == 1 ? 32'd0 : $urandom());
      write_gain(REG_CUR_GAIN, s == 0 ? 32'hFFFF_FFFF : s == 1 ? 32'd0 : $urandom());
      write_gain(REG_EMF_GAIN, s == 0 ? 32'hFFFF_FFFF : s == 1 ? 32'd0 : $urandom());
      for (int i = 0; i < 40; i++)
        send_sample(rand_field(), rand_field(), rand_field(), rand_field());
      drain_results();
    end
  endtask

  // realistic gains with random voltages and currents, some runs without idling
  task automatic test_random_stream();
    write_gain(REG_STEP_TIME, 32'd214748);
    write_gain(REG_STEP_OVER_L, 32'd327680);
    write_gain(REG_RESISTANCE, 32'd65536);
    write_gain(REG_CUR_GAIN, 32'd65536);
    write_gain(REG_EMF_GAIN, 32'd65536);
    for (int i = 0; i < 900; i++) begin
      quiet_in = (i >= 300 && i < 400);
      quiet_out = quiet_in;
      if (i == 500) drain_results();
      if ($urandom_range(9) == 0)
        send_sample(rand_field(), rand_field(), rand_field(), rand_field());
      else
        send_sample($urandom_range(65536 * 200) - 65536 * 100,
                    $urandom_range(65536 * 200) - 65536 * 100,
                    $urandom_range(65536 * 20) - 65536 * 10,
                    $urandom_range(65536 * 20) - 65536 * 10);
    end
    quiet_in = 0;
    quiet_out = 0;
  endtask

  initial begin
    g_ts = 214748; g_tsl = 327680; g_rs = 65536; g_ks = 65536; g_kl = 65536;
    est_ia = 0; est_ib = 0; est_ea = 0; est_eb = 0; last_speed = 0; last_angle = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_gain_sweep();
    test_random_stream();
    drain_results();
    if (errors == 0) begin
      $display("pmsm_back_emf_observer_tb: PASS");
    end else begin
      $display("pmsm_back_emf_observer_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/pbeo_pkg.sv
design/pbeo_ctrl.sv
design/pbeo_datapath.sv
design/pmsm_back_emf_observer.sv
tb/pmsm_back_emf_observer_tb.sv
